/* src/cqs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types and constants of the circular queue with search.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam int DEPTH  = 32;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int SLOT_W = 6;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_DELETED   = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_SEARCH    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CD_INSERTED  = 3'd0,
    CD_OVERFLOW  = 3'd1,
    CD_DELETED   = 3'd2,
    CD_UNDERFLOW = 3'd3,
    CD_FOUND     = 3'd4,
    CD_NOT_FOUND = 3'd5
  } code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL_RD,
    S_SEARCH
  } state_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

/* src/circular_queue_with_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_search_core
// Circular FIFO of 32-bit words in a synchronous RAM, with insert, delete and
// a search walk that reports every matching slot.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_mode, in_value
//  out     | output    | out_valid / out_ready| out_status, out_code,
//          |           |                      | out_data_out, out_slot, out_last
//
//  insert, overflow and underflow: result registered when the request
//  is accepted; delete: the head entry is read from RAM, then the result is
//  loaded from S_DEL_RD; search: one RAM read per entry, each compared with
//  the key, and an empty queue goes straight to not found for the entry
//  reset clears pointers, occupancy and control; RAM contents are not cleared
//  a full output stalls the search walk at a due result and blocks new requests
// ----------------------------------------------------------------------------
module circular_queue_with_search_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [2:0]           out_code,
  output logic signed [31:0]   out_data_out,
  output logic [5:0]           out_slot,
  output logic                 out_last
);
  import cqs_pkg::*;

  word_t  mem [DEPTH];
  word_t  rdata_r;
  logic   we;
  ptr_t   waddr;
  logic   re;
  ptr_t   raddr;

  state_t state_r, state_nxt;
  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  occ_t   occ_r, occ_nxt;
  word_t  key_r, key_nxt;
  ptr_t   ptr_r, ptr_nxt;
  occ_t   issued_r, issued_nxt;
  logic   cmp_v_r, cmp_v_nxt;
  slot_t  cmp_slot_r, cmp_slot_nxt;
  logic   pend_v_r, pend_v_nxt;
  slot_t  pend_slot_r, pend_slot_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic [2:0] status_r, status_nxt;
  logic [2:0] code_r, code_nxt;
  word_t  data_r, data_nxt;
  slot_t  slot_r, slot_nxt;
  logic   last_r, last_nxt;

  logic   out_free;
  logic   load;
  logic   match;
  logic   accept;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= key_nxt;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign match    = cmp_v_r && (rdata_r == key_r);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    key_nxt       = key_r;
    ptr_nxt       = ptr_r;
    issued_nxt    = issued_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_slot_nxt  = cmp_slot_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    in_ready      = 1'b0;
    we            = 1'b0;
    waddr         = tail_r;
    re            = 1'b0;
    raddr         = head_r;
    load          = 1'b0;
    status_nxt    = status_r;
    code_nxt      = code_r;
    data_nxt      = '0;
    slot_nxt      = '0;
    last_nxt      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          case (in_mode)
            MODE_INSERT: begin
              load = 1'b1;
              if (occ_r == OCC_W'(DEPTH)) begin
                status_nxt = ST_OVERFLOW;
                code_nxt   = CD_OVERFLOW;
              end else begin
                key_nxt    = word_t'(in_value);
                we         = 1'b1;
                tail_nxt   = ptr_inc(tail_r);
                occ_nxt    = occ_r + occ_t'(1);
                status_nxt = ST_INSERTED;
                code_nxt   = CD_INSERTED;
              end
            end
            MODE_DELETE: begin
              if (occ_r == '0) begin
                load       = 1'b1;
                status_nxt = ST_UNDERFLOW;
                code_nxt   = CD_UNDERFLOW;
              end else begin
                re        = 1'b1;
                head_nxt  = ptr_inc(head_r);
                occ_nxt   = occ_r - occ_t'(1);
                state_nxt = S_DEL_RD;
              end
            end
            MODE_SEARCH: begin
              key_nxt    = word_t'(in_value);
              ptr_nxt    = head_r;
              issued_nxt = '0;
              cmp_v_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end

      S_DEL_RD: begin
        if (out_free) begin
          load       = 1'b1;
          status_nxt = ST_DELETED;
          code_nxt   = CD_DELETED;
          data_nxt   = rdata_r;
          state_nxt  = S_IDLE;
        end
      end

      S_SEARCH: begin
        status_nxt = ST_SEARCH;
        code_nxt   = CD_FOUND;
        if (!cmp_v_r && (issued_r == occ_r)) begin
          // walk done: flush pending match as final, or report not found
          if (out_free) begin
            load      = 1'b1;
            state_nxt = S_IDLE;
            if (pend_v_r) begin
              slot_nxt = pend_slot_r;
            end else begin
              code_nxt = CD_NOT_FOUND;
            end
          end
        end else if (!(match && pend_v_r && !out_free)) begin
          if (match) begin
            if (pend_v_r) begin
              load     = 1'b1;
              slot_nxt = pend_slot_r;
              last_nxt = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = cmp_slot_r;
          end
          if (issued_r != occ_r) begin
            re           = 1'b1;
            raddr        = ptr_r;
            ptr_nxt      = ptr_inc(ptr_r);
            issued_nxt   = issued_r + occ_t'(1);
            cmp_v_nxt    = 1'b1;
            cmp_slot_nxt = SLOT_W'(ptr_r) + slot_t'(1);
          end else begin
            cmp_v_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      ptr_r       <= '0;
      issued_r    <= '0;
      cmp_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      ptr_r       <= ptr_nxt;
      issued_r    <= issued_nxt;
      cmp_v_r     <= cmp_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    pend_slot_r <= pend_slot_nxt;
    if (load) begin
      status_r <= status_nxt;
      code_r   <= code_nxt;
      data_r   <= data_nxt;
      slot_r   <= slot_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_code     = code_r;
  assign out_data_out = $signed(data_r);
  assign out_slot     = slot_r;
  assign out_last     = last_r;

endmodule

/* src/cqs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqs_checker
// Port-level checks on the result channel of the circular queue with search.
// ----------------------------------------------------------------------------
module cqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [2:0]  out_code,
  input logic [31:0] out_data_out,
  input logic [5:0]  out_slot,
  input logic        out_last
);
  import cqs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_slot)
      && $stable(out_data_out) && $stable(out_last))
    else $error("stalled result changed");

  // only search results can be non-final
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_SEARCH) |-> out_last)
    else $error("non-search result without last");

  // not found is a single result with no slot
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_code == CD_NOT_FOUND) |-> out_last && (out_slot == '0)
      && (out_status == ST_SEARCH))
    else $error("bad not-found result");

  // data only on delete
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DELETED) |-> (out_data_out == '0))
    else $error("data on non-delete result");

endmodule

bind circular_queue_with_search_core cqs_checker u_cqs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_code     (out_code),
  .out_data_out (out_data_out),
  .out_slot     (out_slot),
  .out_last     (out_last)
);
